// ===== design/tcp_receive_state_machine_top_assert.svh =====
// Assertion macros for the TCP receive state machine.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef TCP_RECEIVE_STATE_MACHINE_TOP_ASSERT_SVH
`define TCP_RECEIVE_STATE_MACHINE_TOP_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define TRSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcp_rsm assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define TRSM_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tcp_rsm forbidden condition seen");

`endif

// ===== design/tcp_rsm_pkg.sv =====
`default_nettype none
package tcp_rsm_pkg;

  // Request kinds
  localparam logic ReqSegment = 1'b0;
  localparam logic ReqLoad    = 1'b1;

  // TCP flag bits
  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagPsh = 8'h08;
  localparam logic [7:0] FlagAck = 8'h10;
  localparam logic [7:0] FlagsPshAck = FlagPsh | FlagAck;
  localparam logic [7:0] FlagsSynAck = FlagSyn | FlagAck;
  localparam logic [7:0] FlagsAckFin = FlagAck | FlagFin;

  // Connection states
  localparam logic [3:0] StClosed    = 4'd0;
  localparam logic [3:0] StListen    = 4'd1;
  localparam logic [3:0] StSynSent   = 4'd2;
  localparam logic [3:0] StSynRecv   = 4'd3;
  localparam logic [3:0] StEstab     = 4'd4;
  localparam logic [3:0] StCloseWait = 4'd5;
  localparam logic [3:0] StLastAck   = 4'd6;
  localparam logic [3:0] StFinWait1  = 4'd7;
  localparam logic [3:0] StFinWait2  = 4'd8;
  localparam logic [3:0] StClosing   = 4'd9;
  localparam logic [3:0] StTimeWait  = 4'd10;

  // Wake mask bits
  localparam logic [3:0] WakeSend   = 4'b0001;
  localparam logic [3:0] WakeRecv   = 4'b0010;
  localparam logic [3:0] WakeConn   = 4'b0100;
  localparam logic [3:0] WakeAccept = 4'b1000;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_seq_end;
    logic [31:0] seg_ack;
    logic [15:0] payload_len;
    logic [3:0]  load_state;
    logic [31:0] load_snd_una;
    logic [31:0] load_snd_nxt;
    logic [31:0] load_rcv_nxt;
    logic [15:0] load_rcv_wnd;
  } item_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [31:0] snd_una;
    logic [31:0] snd_nxt;
    logic [31:0] rcv_nxt;
    logic [15:0] rcv_wnd;
  } ctx_t;

  typedef struct packed {
    logic       send_reset;
    logic       send_ctrl;
    logic [7:0] ctrl_flags;
    logic       spawn_child;
    logic       accept_data;
    logic       dropped;
    logic       start_timewait;
    logic [3:0] wake_mask;
  } res_t;

endpackage
`default_nettype wire

// ===== design/tcp_receive_state_machine_top.sv =====
// TCP receive state machine for one connection.
// Input channel (in_valid_i / in_stall_o) carries either a received segment
// header (req_type_i = 0) or a load of the whole connection context
// (req_type_i = 1). Output channel (out_valid_o / out_stall_i) returns exactly
// one result item per input item: the decision flags plus the state, rcv_nxt,
// snd_una and receive window as they stand after that item.
// An item waits in the input register until the result register is free; it
// is then judged against the connection context and lands in the result
// register as the context updates. Throughput: one item per cycle while no
// result is stalled. The judgment is a 32-bit add feeding a 32-bit subtract
// for the window end, a second 32-bit subtract, a 16-bit subtract and a few
// compares between the input register and the context/result registers.
// Back-pressure: while out_stall_i holds a result, the input register keeps
// one further item and in_stall_o rises only when that register is full too.
// Results stay stable while stalled.
// Reset: clears both valid flags and the context to CLOSED with all sequence
// numbers and the window at zero.
`default_nettype none
module tcp_receive_state_machine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  seg_flags_i,
  input  wire logic [31:0] seg_seq_i,
  input  wire logic [31:0] seg_seq_end_i,
  input  wire logic [31:0] seg_ack_i,
  input  wire logic [15:0] payload_len_i,
  input  wire logic [3:0]  load_state_i,
  input  wire logic [31:0] load_snd_una_i,
  input  wire logic [31:0] load_snd_nxt_i,
  input  wire logic [31:0] load_rcv_nxt_i,
  input  wire logic [15:0] load_rcv_wnd_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        send_reset_o,
  output      logic        send_ctrl_o,
  output      logic [7:0]  ctrl_flags_o,
  output      logic        spawn_child_o,
  output      logic        accept_data_o,
  output      logic        dropped_o,
  output      logic        start_timewait_o,
  output      logic [3:0]  wake_mask_o,
  output      logic [3:0]  state_now_o,
  output      logic [31:0] rcv_nxt_now_o,
  output      logic [31:0] snd_una_now_o,
  output      logic [15:0] rcv_wnd_now_o
);
  import tcp_rsm_pkg::*;

  logic  in_valid_q;
  item_t item_q;
  item_t item_d;
  logic  out_valid_q;
  res_t  res_q;
  res_t  res_d;
  ctx_t  ctx_q;
  ctx_t  ctx_d;
  logic  advance;

  // Gather the input fields into one item
  assign item_d = '{
    req_type:     req_type_i,
    seg_flags:    seg_flags_i,
    seg_seq:      seg_seq_i,
    seg_seq_end:  seg_seq_end_i,
    seg_ack:      seg_ack_i,
    payload_len:  payload_len_i,
    load_state:   load_state_i,
    load_snd_una: load_snd_una_i,
    load_snd_nxt: load_snd_nxt_i,
    load_rcv_nxt: load_rcv_nxt_i,
    load_rcv_wnd: load_rcv_wnd_i
  };

  // Move the held item to the result register whenever that register frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register: hold while stalled, otherwise take the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_d;
    end
  end

  tcp_rsm_decide u_decide (
    .item_i (item_q),
    .ctx_i  (ctx_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  // Connection context: advance once per judged item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  // Result register: fill on advance, drain when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // The *_now fields mirror the context, which only moves together with res_q
  assign out_valid_o      = out_valid_q;
  assign send_reset_o     = res_q.send_reset;
  assign send_ctrl_o      = res_q.send_ctrl;
  assign ctrl_flags_o     = res_q.ctrl_flags;
  assign spawn_child_o    = res_q.spawn_child;
  assign accept_data_o    = res_q.accept_data;
  assign dropped_o        = res_q.dropped;
  assign start_timewait_o = res_q.start_timewait;
  assign wake_mask_o      = res_q.wake_mask;
  assign state_now_o      = ctx_q.state;
  assign rcv_nxt_now_o    = ctx_q.rcv_nxt;
  assign snd_una_now_o    = ctx_q.snd_una;
  assign rcv_wnd_now_o    = ctx_q.rcv_wnd;

`include "tcp_receive_state_machine_top_assert.svh"

  // A dropped segment triggers no reply and wakes no one
  `TRSM_ASSERT(a_drop_quiet, (out_valid_o && dropped_o) |-> (!send_reset_o && !send_ctrl_o && wake_mask_o == 4'd0))
  // Control flags are present exactly when a control packet is sent
  `TRSM_ASSERT(a_ctrl_flags, out_valid_o |-> (send_ctrl_o == (ctrl_flags_o != 8'd0)))
  // Context moves only when an item is judged
  `TRSM_ASSERT(a_ctx_hold, !advance |=> $stable(ctx_q))
  // Input stalls only when both registers are full and the output is stalled
  `TRSM_NEVER(a_stall_cause, in_stall_o && !(out_valid_q && out_stall_i))

endmodule
`default_nettype wire

// ===== design/tcp_rsm_decide.sv =====
`default_nettype none
module tcp_rsm_decide (
  input  tcp_rsm_pkg::item_t item_i,
  input  tcp_rsm_pkg::ctx_t  ctx_i,
  output tcp_rsm_pkg::ctx_t  ctx_o,
  output tcp_rsm_pkg::res_t  res_o
);
  import tcp_rsm_pkg::*;

  logic [15:0] wnd_eff;
  logic [31:0] rcv_end;
  logic [31:0] diff_lo;
  logic [31:0] diff_hi;
  logic        win_ok;
  logic        ack_match;
  logic [15:0] wnd_after;
  logic [7:0]  fl;

  assign fl        = item_i.seg_flags;
  assign wnd_eff   = (ctx_i.rcv_wnd == 16'd0) ? 16'd1 : ctx_i.rcv_wnd;
  assign rcv_end   = ctx_i.rcv_nxt + {16'd0, wnd_eff};
  // Wrap-safe compares: sign of the 32-bit difference
  assign diff_lo   = item_i.seg_seq - rcv_end;
  assign diff_hi   = item_i.seg_seq_end - ctx_i.rcv_nxt;
  assign win_ok    = diff_lo[31] && !diff_hi[31];
  assign ack_match = (item_i.seg_ack == ctx_i.snd_nxt);
  assign wnd_after = (item_i.payload_len >= ctx_i.rcv_wnd) ? 16'd0
                   : ctx_i.rcv_wnd - item_i.payload_len;

  always_comb begin
    ctx_o = ctx_i;
    res_o = '0;
    if (item_i.req_type == ReqLoad) begin
      ctx_o.state   = (item_i.load_state > StTimeWait) ? StClosed : item_i.load_state;
      ctx_o.snd_una = item_i.load_snd_una;
      ctx_o.snd_nxt = item_i.load_snd_nxt;
      ctx_o.rcv_nxt = item_i.load_rcv_nxt;
      ctx_o.rcv_wnd = item_i.load_rcv_wnd;
    end else begin
      unique case (ctx_i.state)
        StClosed: begin
          res_o.send_reset = 1'b1;
        end
        StListen: begin
          if ((fl & FlagSyn) != 8'd0) begin
            res_o.spawn_child = 1'b1;
            res_o.send_ctrl   = 1'b1;
            res_o.ctrl_flags  = FlagsSynAck;
          end else begin
            res_o.send_reset = 1'b1;
          end
        end
        StSynSent: begin
          if ((fl & FlagsSynAck) == FlagsSynAck) begin
            ctx_o.rcv_nxt    = item_i.seg_seq_end;
            ctx_o.snd_una    = item_i.seg_ack;
            ctx_o.state      = StEstab;
            res_o.send_ctrl  = 1'b1;
            res_o.ctrl_flags = FlagAck;
            res_o.wake_mask  = WakeConn;
          end else begin
            res_o.send_reset = 1'b1;
          end
        end
        default: begin
          if (!win_ok) begin
            res_o.dropped = 1'b1;
          end else if ((fl & FlagRst) != 8'd0) begin
            ctx_o.state = StClosed;
          end else if ((fl & FlagSyn) != 8'd0) begin
            res_o.send_reset = 1'b1;
            ctx_o.state      = StClosed;
          end else if ((fl & FlagAck) == 8'd0) begin
            res_o.send_reset = 1'b1;
          end else if (fl == FlagsPshAck) begin
            res_o.accept_data = 1'b1;
            ctx_o.rcv_wnd     = wnd_after;
            res_o.wake_mask   = WakeRecv;
            res_o.send_ctrl   = 1'b1;
            res_o.ctrl_flags  = FlagAck;
          end else begin
            ctx_o.snd_una = item_i.seg_ack;
            ctx_o.rcv_nxt = item_i.seg_seq_end;
            if (ctx_i.state == StSynRecv && ack_match) begin
              ctx_o.state     = StEstab;
              res_o.wake_mask = WakeAccept;
            end else if (ctx_i.state == StFinWait1 && ack_match) begin
              ctx_o.state = StFinWait2;
            end else if (ctx_i.state == StFinWait2 && (fl & FlagsAckFin) == FlagsAckFin) begin
              ctx_o.state          = StTimeWait;
              res_o.start_timewait = 1'b1;
              res_o.send_ctrl      = 1'b1;
              res_o.ctrl_flags     = FlagAck;
            end else begin
              if (ctx_i.state == StEstab && (fl & FlagFin) != 8'd0) begin
                ctx_o.state      = StCloseWait;
                res_o.wake_mask  = res_o.wake_mask | WakeRecv;
                res_o.send_ctrl  = 1'b1;
                res_o.ctrl_flags = FlagAck;
              end
              if (ctx_i.state == StLastAck && ack_match) begin
                ctx_o.state = StClosed;
              end
              if (ctx_i.state == StEstab && fl == FlagAck) begin
                res_o.wake_mask = res_o.wake_mask | WakeSend;
              end
            end
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire
